// ===== sv/harmonic_or_linear_wave_oscillator_assert.svh =====
// assertion macros for the wave oscillator
`ifndef HARMONIC_OR_LINEAR_WAVE_OSCILLATOR_ASSERT_SVH
`define HARMONIC_OR_LINEAR_WAVE_OSCILLATOR_ASSERT_SVH

// same-cycle implication
`define HLW_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define HLW_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== sv/hlw_pkg.sv =====
// shared types and constants of the wave oscillator
package hlw_pkg;

  localparam int MAX_POINTS   = 32;
  localparam int SINE_ENTRIES = 1024;
  localparam int SINE_AW      = $clog2(SINE_ENTRIES);
  localparam int AW           = $clog2(MAX_POINTS);
  localparam int PTR_W        = $clog2(MAX_POINTS + 1);

  localparam int DIV_W  = 52;
  localparam int DVS_W  = 16;
  localparam int NB_W   = 6;
  localparam int PROD_W = 62;
  localparam int ACC_W  = 36;
  localparam int MA_W   = 44;
  localparam int MB_W   = 18;
  localparam int SIN_W  = 16;

  localparam logic [NB_W-1:0] NB_MOD  = NB_W'(32);
  localparam logic [NB_W-1:0] NB_PH   = NB_W'(16 + SINE_AW);
  localparam logic [NB_W-1:0] NB_TERM = NB_W'(30);
  localparam logic [NB_W-1:0] NB_IDX  = NB_W'(32);
  localparam logic [NB_W-1:0] NB_SEG  = NB_W'(DIV_W);

  localparam int TERM_SHIFT = 7;
  localparam int OUT_SHIFT  = 21;

  localparam logic signed [PROD_W-1:0] SAMPLE_MAX = 62'sd524287;
  localparam logic signed [PROD_W-1:0] SAMPLE_MIN = -62'sd524288;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    REG_MODE, REG_COUNT, REG_VOLUME, REG_SCOUNT, REG_RES
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_H_RD, ST_H_X, ST_H_MOD, ST_H_PH, ST_H_SY, ST_H_TERM, ST_H_SCALE,
    ST_H_OUT, ST_L_MUL, ST_L_DIV, ST_L_RD, ST_L_CMP, ST_L_RA, ST_L_RB, ST_L_RC,
    ST_L_Y, ST_L_HD, ST_L_HDV, ST_L_QDIV, ST_DONE
  } state_t;

  typedef struct packed {
    logic        mode;
    logic [5:0]  count;
    logic [7:0]  volume;
    logic [15:0] sample_count;
    logic [15:0] resolution;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
    logic [NB_W-1:0]  nbits;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== sv/hlw_div.sv =====
// shared restoring divider, one quotient bit per cycle
module hlw_div (
  input  logic             clk,
  input  logic             rst_n,
  input  hlw_pkg::div_req_t req,
  output hlw_pkg::div_rsp_t rsp
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [hlw_pkg::NB_W-1:0]    cnt_r, cnt_nxt;
  logic [hlw_pkg::DIV_W-1:0]   q_r, q_nxt;
  logic [hlw_pkg::DVS_W-1:0]   rem_r, rem_nxt;
  logic [hlw_pkg::DVS_W-1:0]   dvs_r, dvs_nxt;
  logic [hlw_pkg::DVS_W:0]     trial;
  logic [hlw_pkg::DVS_W:0]     diff;

  always_comb begin
    trial    = {rem_r, q_r[hlw_pkg::DIV_W-1]};
    diff     = trial - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.nbits;
      q_nxt    = req.dividend << (hlw_pkg::NB_W'(hlw_pkg::DIV_W) - req.nbits);
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[hlw_pkg::DVS_W-1:0];
        q_nxt   = {q_r[hlw_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[hlw_pkg::DVS_W-1:0];
        q_nxt   = {q_r[hlw_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == hlw_pkg::NB_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== sv/hlw_sine_rom.sv =====
// full-period sine table in q.14, registered read
module hlw_sine_rom (
  input  logic                              clk,
  input  logic [hlw_pkg::SINE_AW-1:0]       addr,
  output logic signed [hlw_pkg::SIN_W-1:0]  data
);

  typedef logic [hlw_pkg::SINE_ENTRIES-1:0][hlw_pkg::SIN_W-1:0] sine_lut_t;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  function automatic logic [63:0] quarter_sine(input logic [63:0] theta);
    logic [63:0] sq;
    logic [63:0] term;
    logic [63:0] sum;
    sq   = (theta * theta) >> 30;
    term = theta;
    sum  = theta;
    term = ((term * sq) >> 30) / 6;   sum = sum - term;
    term = ((term * sq) >> 30) / 20;  sum = sum + term;
    term = ((term * sq) >> 30) / 42;  sum = sum - term;
    term = ((term * sq) >> 30) / 72;  sum = sum + term;
    term = ((term * sq) >> 30) / 110; sum = sum - term;
    term = ((term * sq) >> 30) / 156; sum = sum + term;
    term = ((term * sq) >> 30) / 210; sum = sum - term;
    term = ((term * sq) >> 30) / 272; sum = sum + term;
    return sum;
  endfunction

  function automatic sine_lut_t build_lut();
    sine_lut_t   lut;
    logic [63:0] q;
    logic [63:0] quad;
    logic [63:0] rem;
    logic [63:0] u;
    logic [63:0] theta;
    logic [63:0] v;
    for (int k = 0; k < hlw_pkg::SINE_ENTRIES; k++) begin
      q     = 64'(4 * k);
      quad  = q >> hlw_pkg::SINE_AW;
      rem   = q & 64'(hlw_pkg::SINE_ENTRIES - 1);
      u     = quad[0] ? (64'(hlw_pkg::SINE_ENTRIES) - rem) : rem;
      theta = (HALF_PI_Q30 * u) >> hlw_pkg::SINE_AW;
      v     = (quarter_sine(theta) + 64'd32768) >> 16;
      if (v > 64'd16384) begin
        v = 64'd16384;
      end
      lut[k] = (quad >= 64'd2) ? hlw_pkg::SIN_W'(-v) : hlw_pkg::SIN_W'(v);
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_lut();

  logic signed [hlw_pkg::SIN_W-1:0] data_r;

  always_ff @(posedge clk) begin
    data_r <= SINE_LUT[addr];
  end

  assign data = data_r;

endmodule

// ===== sv/hlw_table.sv =====
// point table memory, one write and one registered read port
module hlw_table (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [hlw_pkg::AW-1:0]       wr_addr,
  input  logic [15:0]                  wr_x,
  input  logic signed [8:0]            wr_y,
  input  logic [hlw_pkg::AW-1:0]       rd_addr,
  output logic [15:0]                  rd_x,
  output logic signed [8:0]            rd_y
);

  logic [24:0] mem [hlw_pkg::MAX_POINTS];
  logic [24:0] rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_y, wr_x};
    end
    rd_r <= mem[rd_addr];
  end

  assign rd_x = rd_r[15:0];
  assign rd_y = rd_r[24:16];

endmodule

// ===== sv/hlw_seq.sv =====
// sample sequencer with shared multiplier, drives divider, table and rom
module hlw_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hlw_pkg::cfg_t                     cfg,
  input  logic                              start,
  input  logic [15:0]                       start_index,
  output logic                              ready,
  output logic [hlw_pkg::AW-1:0]            tbl_addr,
  input  logic [15:0]                       tbl_x,
  input  logic signed [8:0]                 tbl_y,
  output logic [hlw_pkg::SINE_AW-1:0]       rom_addr,
  input  logic signed [hlw_pkg::SIN_W-1:0]  rom_data,
  output hlw_pkg::div_req_t                 div_req,
  input  hlw_pkg::div_rsp_t                 div_rsp,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [19:0]                       out_value
);

  localparam int PW = hlw_pkg::PROD_W;

  hlw_pkg::state_t state_r, state_nxt;

  logic                             launched_r, launched_nxt;
  logic [15:0]                      idx_r, idx_nxt;
  logic [hlw_pkg::PTR_W-1:0]        o_r, o_nxt;
  logic [hlw_pkg::PTR_W-1:0]        n_r, n_nxt;
  logic [15:0]                      x_r, x_nxt;
  logic signed [8:0]                y_r, y_nxt;
  logic signed [PW-1:0]             prod_r, prod_nxt;
  logic signed [hlw_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [31:0]                      i_r, i_nxt;
  logic signed [16:0]               w_r, w_nxt;
  logic signed [32:0]               d_r, d_nxt;
  logic signed [9:0]                h_r, h_nxt;
  logic [19:0]                      res_r, res_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [19:0]                      out_value_r, out_value_nxt;

  logic signed [hlw_pkg::MA_W-1:0]  mul_a;
  logic signed [hlw_pkg::MB_W-1:0]  mul_b;
  logic signed [PW-1:0]             mul_p;
  logic [PW-1:0]                    mag_p;
  logic [PW-1:0]                    sh_p;
  logic signed [PW-1:0]             hv;
  logic signed [PW-1:0]             qs;
  logic signed [hlw_pkg::ACC_W-1:0] term;
  logic [16:0]                      w_mag;
  logic [16:0]                      x2;
  logic [15:0]                      sc_eff;
  logic [hlw_pkg::PTR_W-1:0]        n_cfg;
  logic                             is_div;
  logic                             div_fin;
  logic                             last_pt;
  logic                             can_load;

  function automatic logic [19:0] sat(input logic signed [PW-1:0] v);
    logic [19:0] r;
    if (v > hlw_pkg::SAMPLE_MAX) begin
      r = hlw_pkg::SAMPLE_MAX[19:0];
    end else if (v < hlw_pkg::SAMPLE_MIN) begin
      r = hlw_pkg::SAMPLE_MIN[19:0];
    end else begin
      r = v[19:0];
    end
    return r;
  endfunction

  assign sc_eff   = (cfg.sample_count == 16'd0) ? 16'd1 : cfg.sample_count;
  assign n_cfg    = (int'(cfg.count) > hlw_pkg::MAX_POINTS) ?
                    hlw_pkg::PTR_W'(hlw_pkg::MAX_POINTS) : hlw_pkg::PTR_W'(cfg.count);
  assign is_div   = (state_r == hlw_pkg::ST_H_MOD) || (state_r == hlw_pkg::ST_H_PH) ||
                    (state_r == hlw_pkg::ST_H_TERM) || (state_r == hlw_pkg::ST_L_DIV) ||
                    (state_r == hlw_pkg::ST_L_QDIV);
  assign div_fin  = launched_r && div_rsp.done;
  assign last_pt  = (o_r + 1'b1) == n_r;
  assign can_load = !out_valid_r || out_ready;
  assign mag_p    = prod_r[PW-1] ? PW'(-prod_r) : PW'(prod_r);
  assign sh_p     = mag_p >> hlw_pkg::OUT_SHIFT;
  assign hv       = prod_r[PW-1] ? -$signed(sh_p) : $signed(sh_p);
  assign w_mag    = w_r[16] ? 17'(-w_r) : 17'(w_r);
  assign x2       = (o_r == n_r) ? {1'b0, cfg.resolution} : {1'b0, tbl_x};
  assign term     = prod_r[PW-1] ? -$signed(div_rsp.quot[hlw_pkg::ACC_W-1:0])
                                 : $signed(div_rsp.quot[hlw_pkg::ACC_W-1:0]);
  assign qs       = (prod_r[PW-1] ^ w_r[16]) ? -$signed({10'b0, div_rsp.quot})
                                             : $signed({10'b0, div_rsp.quot});
  assign mul_p    = mul_a * mul_b;
  assign rom_addr = div_rsp.quot[hlw_pkg::SINE_AW-1:0];
  assign ready    = (state_r == hlw_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hlw_pkg::ST_IDLE: begin
        if (start) begin
          if (cfg.mode) begin
            state_nxt = hlw_pkg::ST_L_MUL;
          end else if (n_cfg == '0) begin
            state_nxt = hlw_pkg::ST_H_SCALE;
          end else begin
            state_nxt = hlw_pkg::ST_H_RD;
          end
        end
      end
      hlw_pkg::ST_H_RD:    state_nxt = hlw_pkg::ST_H_X;
      hlw_pkg::ST_H_X: begin
        if (tbl_x != 16'd0) begin
          state_nxt = hlw_pkg::ST_H_MOD;
        end else if (last_pt) begin
          state_nxt = hlw_pkg::ST_H_SCALE;
        end else begin
          state_nxt = hlw_pkg::ST_H_RD;
        end
      end
      hlw_pkg::ST_H_MOD:   if (div_fin) state_nxt = hlw_pkg::ST_H_PH;
      hlw_pkg::ST_H_PH:    if (div_fin) state_nxt = hlw_pkg::ST_H_SY;
      hlw_pkg::ST_H_SY:    state_nxt = hlw_pkg::ST_H_TERM;
      hlw_pkg::ST_H_TERM: begin
        if (div_fin) begin
          state_nxt = last_pt ? hlw_pkg::ST_H_SCALE : hlw_pkg::ST_H_RD;
        end
      end
      hlw_pkg::ST_H_SCALE: state_nxt = hlw_pkg::ST_H_OUT;
      hlw_pkg::ST_H_OUT:   state_nxt = hlw_pkg::ST_DONE;
      hlw_pkg::ST_L_MUL:   state_nxt = hlw_pkg::ST_L_DIV;
      hlw_pkg::ST_L_DIV: begin
        if (div_fin) begin
          state_nxt = (n_r == '0) ? hlw_pkg::ST_DONE : hlw_pkg::ST_L_RD;
        end
      end
      hlw_pkg::ST_L_RD:    state_nxt = hlw_pkg::ST_L_CMP;
      hlw_pkg::ST_L_CMP: begin
        if ({16'b0, tbl_x} <= i_r && !last_pt) begin
          state_nxt = hlw_pkg::ST_L_RD;
        end else begin
          state_nxt = hlw_pkg::ST_L_RA;
        end
      end
      hlw_pkg::ST_L_RA:    state_nxt = hlw_pkg::ST_L_RB;
      hlw_pkg::ST_L_RB:    state_nxt = hlw_pkg::ST_L_RC;
      hlw_pkg::ST_L_RC:    state_nxt = hlw_pkg::ST_L_Y;
      hlw_pkg::ST_L_Y:     state_nxt = hlw_pkg::ST_L_HD;
      hlw_pkg::ST_L_HD: begin
        if (d_r == '0 || w_r == '0) begin
          state_nxt = hlw_pkg::ST_DONE;
        end else begin
          state_nxt = hlw_pkg::ST_L_HDV;
        end
      end
      hlw_pkg::ST_L_HDV:   state_nxt = hlw_pkg::ST_L_QDIV;
      hlw_pkg::ST_L_QDIV:  if (div_fin) state_nxt = hlw_pkg::ST_DONE;
      hlw_pkg::ST_DONE:    if (can_load) state_nxt = hlw_pkg::ST_IDLE;
      default:             state_nxt = hlw_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    launched_nxt     = launched_r;
    idx_nxt          = idx_r;
    o_nxt            = o_r;
    n_nxt            = n_r;
    x_nxt            = x_r;
    y_nxt            = y_r;
    prod_nxt         = prod_r;
    acc_nxt          = acc_r;
    i_nxt            = i_r;
    w_nxt            = w_r;
    d_nxt            = d_r;
    h_nxt            = h_r;
    res_nxt          = res_r;
    mul_a            = '0;
    mul_b            = '0;
    tbl_addr         = o_r[hlw_pkg::AW-1:0];
    div_req.start    = 1'b0;
    div_req.dividend = {20'b0, prod_r[31:0]};
    div_req.divisor  = sc_eff;
    div_req.nbits    = hlw_pkg::NB_MOD;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_value_nxt    = out_value_r;

    if (is_div) begin
      if (!launched_r) begin
        div_req.start = 1'b1;
        launched_nxt  = 1'b1;
      end else if (div_rsp.done) begin
        launched_nxt  = 1'b0;
      end
    end

    case (state_r)
      hlw_pkg::ST_IDLE: begin
        if (start) begin
          idx_nxt = start_index;
          n_nxt   = n_cfg;
          o_nxt   = '0;
          acc_nxt = '0;
          res_nxt = '0;
        end
      end
      hlw_pkg::ST_H_X: begin
        x_nxt    = tbl_x;
        y_nxt    = tbl_y;
        mul_a    = $signed({28'b0, idx_r});
        mul_b    = $signed({2'b0, tbl_x});
        prod_nxt = mul_p;
        if (tbl_x == 16'd0) begin
          o_nxt = o_r + 1'b1;
        end
      end
      hlw_pkg::ST_H_PH: begin
        div_req.dividend = hlw_pkg::DIV_W'({div_rsp.rem, hlw_pkg::SINE_AW'(0)});
        div_req.nbits    = hlw_pkg::NB_PH;
      end
      hlw_pkg::ST_H_SY: begin
        mul_a    = hlw_pkg::MA_W'(rom_data);
        mul_b    = hlw_pkg::MB_W'(y_r);
        prod_nxt = mul_p;
      end
      hlw_pkg::ST_H_TERM: begin
        div_req.dividend = {mag_p[hlw_pkg::DIV_W-hlw_pkg::TERM_SHIFT-1:0],
                            hlw_pkg::TERM_SHIFT'(0)};
        div_req.divisor  = x_r;
        div_req.nbits    = hlw_pkg::NB_TERM;
        if (div_fin) begin
          acc_nxt = acc_r + term;
          o_nxt   = o_r + 1'b1;
        end
      end
      hlw_pkg::ST_H_SCALE: begin
        mul_a    = hlw_pkg::MA_W'(acc_r);
        mul_b    = $signed({10'b0, cfg.volume});
        prod_nxt = mul_p;
      end
      hlw_pkg::ST_H_OUT: begin
        res_nxt = sat(hv);
      end
      hlw_pkg::ST_L_MUL: begin
        mul_a    = $signed({28'b0, idx_r});
        mul_b    = $signed({2'b0, cfg.resolution});
        prod_nxt = mul_p;
      end
      hlw_pkg::ST_L_DIV: begin
        div_req.nbits = hlw_pkg::NB_IDX;
        if (div_fin) begin
          i_nxt   = div_rsp.quot[31:0];
          o_nxt   = '0;
          res_nxt = '0;
        end
      end
      hlw_pkg::ST_L_CMP: begin
        if ({16'b0, tbl_x} <= i_r) begin
          o_nxt = o_r + 1'b1;
        end
      end
      hlw_pkg::ST_L_RA: begin
        tbl_addr = (o_r == '0) ? '0 : hlw_pkg::AW'(o_r - 1'b1);
      end
      hlw_pkg::ST_L_RB: begin
        x_nxt    = tbl_x;
        y_nxt    = tbl_y;
        tbl_addr = (o_r == n_r) ? '0 : o_r[hlw_pkg::AW-1:0];
      end
      hlw_pkg::ST_L_RC: begin
        w_nxt = $signed(x2) - $signed({1'b0, x_r});
        d_nxt = $signed({1'b0, i_r}) - $signed({17'b0, x_r});
        h_nxt = 10'(tbl_y) - 10'(y_r);
      end
      hlw_pkg::ST_L_Y: begin
        mul_a   = hlw_pkg::MA_W'(y_r);
        mul_b   = $signed({10'b0, cfg.volume});
        acc_nxt = mul_p[hlw_pkg::ACC_W-1:0];
      end
      hlw_pkg::ST_L_HD: begin
        mul_a    = hlw_pkg::MA_W'(d_r);
        mul_b    = hlw_pkg::MB_W'(h_r);
        prod_nxt = mul_p;
        res_nxt  = sat(PW'(acc_r));
      end
      hlw_pkg::ST_L_HDV: begin
        mul_a    = prod_r[hlw_pkg::MA_W-1:0];
        mul_b    = $signed({10'b0, cfg.volume});
        prod_nxt = mul_p;
      end
      hlw_pkg::ST_L_QDIV: begin
        div_req.dividend = mag_p[hlw_pkg::DIV_W-1:0];
        div_req.divisor  = w_mag[hlw_pkg::DVS_W-1:0];
        div_req.nbits    = hlw_pkg::NB_SEG;
        if (div_fin) begin
          res_nxt = sat(PW'(acc_r) + qs);
        end
      end
      hlw_pkg::ST_DONE: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hlw_pkg::ST_IDLE;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launched_r  <= launched_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r       <= idx_nxt;
    o_r         <= o_nxt;
    n_r         <= n_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    prod_r      <= prod_nxt;
    acc_r       <= acc_nxt;
    i_r         <= i_nxt;
    w_r         <= w_nxt;
    d_r         <= d_nxt;
    h_r         <= h_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

endmodule

// ===== sv/harmonic_or_linear_wave_oscillator.sv =====
// top level of the harmonic or linear wave oscillator
//
// input stream: a beat with tuser 0 writes one table point (slot, x, y); it is
// taken while idle and gives no output. a beat with tuser 1 asks for the
// sample at sample_index; the block then drops in_tready until the sample sits
// in the output register.
// harmonic mode: per point a multiply, three divisions of 32, 26 and 30
// bits on the shared divider and a rom read; a point with x 0 skips the
// divisions and the rom read. linear mode: the index product and the index
// division, a table read per point searched, then the segment fetch and the
// 52-bit segment division. the divider makes one quotient bit each cycle.
// output: out_tvalid stays high with the sample held until out_tready; a
// stalled output holds the next sample in its final state.
// registers must be written over the apb port only while the block is idle;
// the block does not enforce this. reset clears the registers to defaults
// and empties the output; table points hold nothing defined until written.
module harmonic_or_linear_wave_oscillator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // point_slot, point_x, point_y, sample_index
  input  logic [0:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // sample_value
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  `include "harmonic_or_linear_wave_oscillator_assert.svh"

  hlw_pkg::cfg_t     cfg_r, cfg_nxt;
  hlw_pkg::div_req_t div_req;
  hlw_pkg::div_rsp_t div_rsp;
  hlw_pkg::reg_idx_t reg_idx;

  logic                              in_fire;
  logic                              cfg_wr;
  logic                              tbl_wr;
  logic [4:0]                        in_slot;
  logic [15:0]                       in_x;
  logic signed [8:0]                 in_y;
  logic [15:0]                       in_index;
  logic [hlw_pkg::AW-1:0]            tbl_addr;
  logic [15:0]                       tbl_x;
  logic signed [8:0]                 tbl_y;
  logic [hlw_pkg::SINE_AW-1:0]       rom_addr;
  logic signed [hlw_pkg::SIN_W-1:0]  rom_data;
  logic                              seq_ready;
  logic [19:0]                       out_value;

  assign in_slot  = in_tdata[4:0];
  assign in_x     = in_tdata[20:5];
  assign in_y     = in_tdata[29:21];
  assign in_index = in_tdata[45:30];

  assign in_tready  = seq_ready;
  assign in_fire    = in_tvalid && seq_ready;
  assign tbl_wr     = in_fire && (in_tuser[0] == hlw_pkg::CMD_WRITE) &&
                      (int'(in_slot) < hlw_pkg::MAX_POINTS);
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = hlw_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        hlw_pkg::REG_MODE:   cfg_nxt.mode         = cfg_pwdata[0];
        hlw_pkg::REG_COUNT:  cfg_nxt.count        = cfg_pwdata[5:0];
        hlw_pkg::REG_VOLUME: cfg_nxt.volume       = cfg_pwdata[7:0];
        hlw_pkg::REG_SCOUNT: cfg_nxt.sample_count = cfg_pwdata[15:0];
        hlw_pkg::REG_RES:    cfg_nxt.resolution   = cfg_pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      hlw_pkg::REG_MODE:   cfg_prdata = {31'b0, cfg_r.mode};
      hlw_pkg::REG_COUNT:  cfg_prdata = {26'b0, cfg_r.count};
      hlw_pkg::REG_VOLUME: cfg_prdata = {24'b0, cfg_r.volume};
      hlw_pkg::REG_SCOUNT: cfg_prdata = {16'b0, cfg_r.sample_count};
      hlw_pkg::REG_RES:    cfg_prdata = {16'b0, cfg_r.resolution};
      default:             cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode         <= 1'b0;
      cfg_r.count        <= '0;
      cfg_r.volume       <= '0;
      cfg_r.sample_count <= 16'd1;
      cfg_r.resolution   <= 16'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hlw_table u_table (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (in_slot[hlw_pkg::AW-1:0]),
    .wr_x    (in_x),
    .wr_y    (in_y),
    .rd_addr (tbl_addr),
    .rd_x    (tbl_x),
    .rd_y    (tbl_y)
  );

  hlw_sine_rom u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  hlw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  hlw_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .start       (in_fire && (in_tuser[0] == hlw_pkg::CMD_SAMPLE)),
    .start_index (in_index),
    .ready       (seq_ready),
    .tbl_addr    (tbl_addr),
    .tbl_x       (tbl_x),
    .tbl_y       (tbl_y),
    .rom_addr    (rom_addr),
    .rom_data    (rom_data),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_value   (out_value)
  );

  assign out_tdata = {4'b0, out_value};

  `HLW_ASSERT_NXT(a_sample_holds_input, in_tvalid && in_tready && in_tuser[0], !in_tready, "input ready right after a sample beat")
  `HLW_ASSERT_NXT(a_write_no_result, in_tvalid && in_tready && !in_tuser[0] && !out_tvalid, !out_tvalid, "write beat produced a result")
  `HLW_ASSERT_IMP(a_div_only_busy, div_rsp.busy, !in_tready, "divider running while input ready")

endmodule

// ===== bench/tb_harmonic_or_linear_wave_oscillator.sv =====
// testbench: table writes and sample requests in both wave modes, checked against a predictor
`timescale 1ns / 1ps

module tb_harmonic_or_linear_wave_oscillator;

  localparam int LIMIT     = 20000000;
  localparam int REG_SPARE = 5;
  localparam int HOLDOFF   = 40;

  class sample_board;
    logic        mode;
    logic [5:0]  count;
    logic [7:0]  volume;
    logic [15:0] scount;
    logic [15:0] res;
    logic [15:0] tab_x [hlw_pkg::MAX_POINTS];
    logic signed [8:0] tab_y [hlw_pkg::MAX_POINTS];
    int sine [hlw_pkg::SINE_ENTRIES];
    logic [19:0] samples_due [$];

    function new();
      longint unsigned q, quad, rem, u, theta, v;
      for (int k = 0; k < hlw_pkg::SINE_ENTRIES; k++) begin
        q = 4 * k;
        quad = q / hlw_pkg::SINE_ENTRIES;
        rem = q % hlw_pkg::SINE_ENTRIES;
        u = quad[0] ? hlw_pkg::SINE_ENTRIES - rem : rem;
        theta = 64'd1686629713 * u / hlw_pkg::SINE_ENTRIES;
        v = (quarter_sine(theta) + 32768) >> 16;
        if (v > 16384) v = 16384;
        sine[k] = (quad >= 2) ? -int'(v) : int'(v);
      end
      mode = 0; count = 0; volume = 0; scount = 1; res = 1;
    endfunction

    function longint unsigned quarter_sine(longint unsigned theta);
      longint unsigned sq, term, sum;
      sq = (theta * theta) >> 30;
      term = theta;
      sum = theta;
      for (int n = 1; n <= 8; n++) begin
        term = ((term * sq) >> 30) / ((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum -= term;
        else sum += term;
      end
      return sum;
    endfunction

    function void set_reg(int idx, logic [31:0] val);
      case (idx)
        hlw_pkg::REG_MODE:   mode = val[0];
        hlw_pkg::REG_COUNT:  count = val[5:0];
        hlw_pkg::REG_VOLUME: volume = val[7:0];
        hlw_pkg::REG_SCOUNT: scount = val[15:0];
        hlw_pkg::REG_RES:    res = val[15:0];
        default: ;
      endcase
    endfunction

    function longint clamp(longint v);
      if (v > 524287) return 524287;
      if (v < -524288) return -524288;
      return v;
    endfunction

    function logic [19:0] predict(logic [15:0] index);
      longint sc, n, acc, x, ph, i, x1, y1, x2, y2, w, d, h, v;
      int c;
      sc = (scount == 0) ? 1 : scount;
      n = (count > hlw_pkg::MAX_POINTS) ? hlw_pkg::MAX_POINTS : count;
      if (mode == 1'b0) begin
        acc = 0;
        for (int o = 0; o < n; o++) begin
          x = tab_x[o];
          if (x == 0) continue;
          ph = ((x * index) % sc) * hlw_pkg::SINE_ENTRIES / sc;
          acc += (longint'(sine[ph]) * longint'(tab_y[o]) * 128) / x;
        end
        v = clamp((acc * longint'(volume)) / 2097152);
      end else if (n == 0) begin
        v = 0;
      end else begin
        i = (longint'(res) * index) / sc;
        c = 0;
        while (c < n && longint'(tab_x[c]) <= i) c++;
        if (c == n) begin
          x1 = tab_x[n-1]; y1 = tab_y[n-1]; x2 = res; y2 = tab_y[0];
        end else if (c > 0) begin
          x1 = tab_x[c-1]; y1 = tab_y[c-1]; x2 = tab_x[c]; y2 = tab_y[c];
        end else begin
          x1 = tab_x[0]; y1 = tab_y[0]; x2 = x1; y2 = y1;
        end
        w = x2 - x1;
        d = i - x1;
        h = y2 - y1;
        v = y1 * longint'(volume);
        if (d != 0 && w != 0) v += (h * d * longint'(volume)) / w;
        v = clamp(v);
      end
      return v[19:0];
    endfunction

    function void note_beat(logic cmd, logic [4:0] slot, logic [15:0] x,
                            logic [8:0] y, logic [15:0] index);
      if (cmd == hlw_pkg::CMD_WRITE) begin
        tab_x[slot] = x;
        tab_y[slot] = y;
      end else begin
        samples_due.push_back(predict(index));
      end
    endfunction

    function bit check_beat(logic [23:0] data, output string msg);
      logic [19:0] want;
      if (samples_due.size() == 0) begin
        msg = $sformatf("unexpected sample %h", data);
        return 0;
      end
      want = samples_due.pop_front();
      if (data !== {4'b0, want}) begin
        msg = $sformatf("sample_value got %h want %h", data, want);
        return 0;
      end
      return 1;
    endfunction

    function int pending();
      return samples_due.size();
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [23:0] out_tdata;
  logic        cfg_psel = 0;
  logic        cfg_penable = 0;
  logic        cfg_pwrite = 0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  harmonic_or_linear_wave_oscillator dut (.*);

  sample_board board = new();
  int  errors = 0;
  int  cycles = 0;
  int  items_sent = 0;
  bit  quiet = 0;

  always #10 clk = ~clk;

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) out_tready <= quiet || ($urandom_range(99) >= 27);

  always @(negedge clk) begin
    string msg;
    if (rst_n && out_tvalid && out_tready) begin
      if (!board.check_beat(out_tdata, msg)) report(msg);
    end
  end

  task automatic send_beat(logic cmd, logic [4:0] slot, logic [15:0] x,
                           logic [8:0] y, logic [15:0] index);
    while (!quiet && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {2'b0, index, y, x, slot};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    board.note_beat(cmd, slot, x, y, index);
    items_sent++;
    @(posedge clk);
  endtask

  task automatic put_point(int slot, int x, int y);
    send_beat(hlw_pkg::CMD_WRITE, slot[4:0], x[15:0], y[8:0], 16'($urandom));
  endtask

  task automatic get_sample(int index);
    send_beat(hlw_pkg::CMD_SAMPLE, 5'($urandom), 16'($urandom), 9'($urandom),
              index[15:0]);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (HOLDOFF) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [31:0] val);
    in_tvalid   <= 1'b0;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 5'(4 * idx);
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    board.set_reg(idx, val);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int pick16();
    case ($urandom_range(4))
      0: return 0;
      1: return 1;
      2: return 65535;
      3: return $urandom_range(1, 100);
      default: return $urandom_range(65535);
    endcase
  endfunction

  task automatic run_phase(int phase);
    int mode, cnt, used, heavy, x, step, res, pct;
    mode = $urandom_range(1);
    case ($urandom_range(9))
      0: cnt = 0;
      1: cnt = $urandom_range(33, 63);
      2: cnt = 32;
      default: cnt = $urandom_range(1, 6);
    endcase
    if (phase == 1) cnt = 32;
    used = (cnt > hlw_pkg::MAX_POINTS) ? hlw_pkg::MAX_POINTS : cnt;
    res = pick16();
    if (res == 0) res = 1;
    write_reg(hlw_pkg::REG_MODE, mode);
    write_reg(hlw_pkg::REG_COUNT, cnt);
    write_reg(hlw_pkg::REG_VOLUME, ($urandom_range(2) == 0) ? 255 : $urandom_range(255));
    write_reg(hlw_pkg::REG_SCOUNT, pick16());
    write_reg(hlw_pkg::REG_RES, res);
    heavy = (mode == 0 && used > 8);
    quiet = (phase == 3);
    x = $urandom_range(3);
    step = (used == 0) ? 1 : res / used + 1;
    for (int s = 0; s < used; s++) begin
      if (mode == 1) begin
        put_point(s, x, $urandom_range(256) - 128);
        x += $urandom_range(step);
      end else begin
        put_point(s, ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(40),
                  $urandom_range(256) - 128);
      end
    end
    pct = heavy ? 20 : 70;
    for (int k = 0; k < 110; k++) begin
      if ($urandom_range(99) < pct) get_sample($urandom_range(65535));
      else put_point($urandom_range(31), $urandom_range(65535), $urandom_range(511));
    end
    drain();
    quiet = 0;
  endtask

  initial begin
    int phase;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table at reset defaults
    get_sample(0);
    get_sample(65535);
    drain();

    // harmonic: zero harmonic, extremes of x and y
    put_point(0, 0, 128);
    put_point(1, 1, 127);
    put_point(2, 65535, -128);
    put_point(3, 3, -1);
    write_reg(hlw_pkg::REG_COUNT, 4);
    write_reg(hlw_pkg::REG_VOLUME, 255);
    write_reg(hlw_pkg::REG_SCOUNT, 64);
    get_sample(0);
    get_sample(16);
    get_sample(65535);
    drain();
    write_reg(hlw_pkg::REG_SCOUNT, 0);
    get_sample(7);
    drain();

    // linear: zero-width segment, d of zero, wrap past last point
    write_reg(hlw_pkg::REG_MODE, 1);
    write_reg(hlw_pkg::REG_RES, 65535);
    write_reg(hlw_pkg::REG_SCOUNT, 65535);
    put_point(0, 10, -128);
    put_point(1, 100, 128);
    put_point(2, 100, 50);
    put_point(3, 40000, -7);
    get_sample(0);
    get_sample(10);
    get_sample(100);
    get_sample(65535);
    drain();
    write_reg(REG_SPARE, 32'hffff_ffff);
    write_reg(hlw_pkg::REG_COUNT, 0);
    get_sample(5);
    drain();

    phase = 0;
    while (items_sent < 1550) begin
      run_phase(phase);
      phase++;
    end

    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
